// ----- hdl/unicode_escape_to_utf8_unit_macros.svh -----
// assertion macros for the unicode escape to utf-8 unit
`ifndef UNICODE_ESCAPE_TO_UTF8_UNIT_MACROS_SVH
`define UNICODE_ESCAPE_TO_UTF8_UNIT_MACROS_SVH

`ifndef SYNTH
`define UETU_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`define UETU_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define UETU_ASSERT_IMP(label, clk, rst_n, cond, expr)
`define UETU_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ----- hdl/uetu_pkg.sv -----
// shared types, constants and functions for the unicode escape to utf-8 unit
package uetu_pkg;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] LETTER_U  = 8'h75;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic            bad;
        logic [1:0]      cnt;
    } uetu_job_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } uetu_q_stat_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_HELD   = 3'b010,
        MODE_DIGITS = 3'b100
    } uetu_mode_t;

    // {bad, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        unique case (b) inside
            [8'h30:8'h39]: r = {1'b0, 4'(b - 8'h30)};
            [8'h61:8'h66]: r = {1'b0, 4'(b - 8'h61 + 8'd10)};
            [8'h41:8'h46]: r = {1'b0, 4'(b - 8'h41 + 8'd10)};
            default:       r = 5'b10000;
        endcase
        return r;
    endfunction

    function automatic uetu_job_t utf8_encode(input logic [15:0] cp, input logic bad);
        uetu_job_t j;
        j = '0;
        j.bad = bad;
        if (cp <= 16'h007F)
        begin
            j.bytes[0] = cp[7:0];
            j.cnt = 2'd1;
        end
        else if (cp <= 16'h07FF)
        begin
            j.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            j.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            j.cnt = 2'd2;
        end
        else
        begin
            j.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
            j.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            j.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            j.cnt = 2'd3;
        end
        return j;
    endfunction

endpackage

// ----- hdl/uetu_front.sv -----
// front end: accepts input beats, tracks escape state, builds output jobs
module uetu_front
    import uetu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // in_byte
    input  logic         s_axis_tuser,  // flush
    input  uetu_q_stat_t q_stat,
    output logic         q_push,
    output uetu_job_t    q_job
);

    uetu_mode_t  mode_reg, mode_next;
    logic [1:0]  count_reg, count_next;
    logic [11:0] accum_reg, accum_next;
    logic        err_reg, err_next;
    logic [4:0]  hv;
    logic        accept;

    assign s_axis_tready = !q_stat.full;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign hv = hex_value(s_axis_tdata);

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        accum_next = accum_reg;
        err_next   = err_reg;
        q_push     = 1'b0;
        q_job      = '0;
        if (accept)
        begin
            if (s_axis_tuser)
            begin
                if (mode_reg == MODE_HELD)
                begin
                    q_push = 1'b1;
                    q_job.bytes[0] = BACKSLASH;
                    q_job.cnt = 2'd1;
                end
                mode_next  = MODE_NORMAL;
                count_next = '0;
                accum_next = '0;
                err_next   = 1'b0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_HELD:
                    begin
                        if (s_axis_tdata == LETTER_U)
                        begin
                            mode_next  = MODE_DIGITS;
                            count_next = '0;
                            accum_next = '0;
                            err_next   = 1'b0;
                        end
                        else if (s_axis_tdata == BACKSLASH)
                        begin
                            q_push = 1'b1;
                            q_job.bytes[0] = BACKSLASH;
                            q_job.cnt = 2'd1;
                        end
                        else
                        begin
                            q_push = 1'b1;
                            q_job.bytes[0] = BACKSLASH;
                            q_job.bytes[1] = s_axis_tdata;
                            q_job.cnt = 2'd2;
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_DIGITS:
                    begin
                        if (count_reg == 2'd3)
                        begin
                            q_push = 1'b1;
                            q_job = utf8_encode({accum_reg, hv[3:0]}, err_reg | hv[4]);
                            mode_next  = MODE_NORMAL;
                            count_next = '0;
                            accum_next = '0;
                            err_next   = 1'b0;
                        end
                        else
                        begin
                            accum_next = {accum_reg[7:0], hv[3:0]};
                            count_next = count_reg + 2'd1;
                            err_next   = err_reg | hv[4];
                        end
                    end
                    MODE_NORMAL:
                    begin
                        if (s_axis_tdata == BACKSLASH)
                        begin
                            mode_next = MODE_HELD;
                        end
                        else
                        begin
                            q_push = 1'b1;
                            q_job.bytes[0] = s_axis_tdata;
                            q_job.cnt = 2'd1;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_NORMAL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= '0;
            accum_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ----- hdl/uetu_queue.sv -----
// job queue between front end and output serializer
module uetu_queue
    import uetu_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  uetu_job_t    push_job,
    input  logic         pop,
    output uetu_job_t    head_job,
    output uetu_q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uetu_job_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_job = mem[rd_ptr_reg];
    assign stat.not_empty = count_reg != '0;
    assign stat.full = count_reg == CNT_W'(DEPTH);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/uetu_back.sv -----
// output serializer: sends one byte of the current job per beat
module uetu_back
    import uetu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  uetu_job_t    head_job,
    input  uetu_q_stat_t q_stat,
    output logic         q_pop,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,  // out_byte
    output logic         m_axis_tuser,  // bad_digit
    output logic         m_axis_tlast   // last
);

    uetu_job_t  job_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       beat;
    logic       last_byte;

    assign last_byte     = idx_reg == (job_reg.cnt - 2'd1);
    assign beat          = valid_reg && m_axis_tready;
    assign q_pop         = q_stat.not_empty && (!valid_reg || (beat && last_byte));
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = job_reg.bytes[idx_reg];
    assign m_axis_tuser  = job_reg.bad;
    assign m_axis_tlast  = last_byte;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= head_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= '0;
            end
            else if (beat)
            begin
                if (last_byte)
                    valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

// ----- hdl/unicode_escape_to_utf8_unit.sv -----
// top level: \uXXXX escape to utf-8 stream filter
// path: each job is registered in the job queue, then in the serializer's job register
// throughput: one input beat per cycle while the job queue has room
// output: one byte per cycle, sink permitting; an escape's last digit yields up to 3 beats
// reset: rst_n asynchronous active low, clears escape state, queue and output valid
module unicode_escape_to_utf8_unit
    import uetu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tuser,   // flush
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tuser,   // bad_digit
    output logic       m_axis_tlast    // last
);

`include "unicode_escape_to_utf8_unit_macros.svh"

    uetu_q_stat_t q_stat;
    uetu_job_t    push_job, head_job;
    logic         q_push, q_pop;

    uetu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    uetu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    uetu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `UETU_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_stat.full)
    `UETU_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, q_stat.not_empty)
    `UETU_ASSERT_NEXT(a_push_fills, clk, rst_n, q_push && !q_pop, q_stat.not_empty)

endmodule

// ----- tb/sv/unicode_escape_to_utf8_unit_tb.sv -----
// testbench for the unicode escape to utf-8 unit: streams bytes and escapes, checks each beat
`timescale 1ns / 1ps

module unicode_escape_to_utf8_unit_tb;
    import uetu_pkg::*;

    localparam int IDLE_PCT    = 9;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 100000;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       last;
    } utf8_beat_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // in_byte
    logic       s_axis_tuser;   // flush
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // out_byte
    logic       m_axis_tuser;   // bad_digit
    logic       m_axis_tlast;   // last

    utf8_beat_t expected_utf8_q[$];
    int         mismatches;
    int         items_sent;
    int         hold_requests;
    int         cycle_count;
    bit         quiet;

    uetu_mode_t  esc_mode;
    logic [1:0]  esc_digits;
    logic [15:0] esc_code;
    logic        esc_bad;

    unicode_escape_to_utf8_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic bit is_hex(input logic [7:0] b);
        return (b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LF) ||
               (b >= CH_UA && b <= CH_UF);
    endfunction

    task automatic predict_utf8(input logic [7:0] b, input logic fl);
        utf8_beat_t beats[$];
        logic [3:0] nib;
        if (fl)
        begin
            if (esc_mode == MODE_HELD)
                beats.push_back({BACKSLASH, 1'b0, 1'b0});
            esc_mode = MODE_NORMAL;
            esc_digits = '0;
            esc_code = '0;
            esc_bad = 1'b0;
        end
        else if (esc_mode == MODE_DIGITS)
        begin
            if (b >= CH_0 && b <= CH_9)
                nib = 4'(b - CH_0);
            else if (b >= CH_LA && b <= CH_LF)
                nib = 4'(b - CH_LA + 8'd10);
            else if (b >= CH_UA && b <= CH_UF)
                nib = 4'(b - CH_UA + 8'd10);
            else
            begin
                nib = 4'd0;
                esc_bad = 1'b1;
            end
            esc_code = {esc_code[11:0], nib};
            if (esc_digits == 2'd3)
            begin
                if (esc_code <= 16'h007F)
                    beats.push_back({esc_code[7:0], esc_bad, 1'b0});
                else if (esc_code <= 16'h07FF)
                begin
                    beats.push_back({3'b110, esc_code[10:6], esc_bad, 1'b0});
                    beats.push_back({2'b10, esc_code[5:0], esc_bad, 1'b0});
                end
                else
                begin
                    beats.push_back({4'b1110, esc_code[15:12], esc_bad, 1'b0});
                    beats.push_back({2'b10, esc_code[11:6], esc_bad, 1'b0});
                    beats.push_back({2'b10, esc_code[5:0], esc_bad, 1'b0});
                end
                esc_mode = MODE_NORMAL;
                esc_digits = '0;
                esc_code = '0;
                esc_bad = 1'b0;
            end
            else
                esc_digits = esc_digits + 2'd1;
        end
        else if (esc_mode == MODE_HELD && b == LETTER_U)
        begin
            esc_mode = MODE_DIGITS;
            esc_digits = '0;
            esc_code = '0;
            esc_bad = 1'b0;
        end
        else
        begin
            // held backslash not starting an escape goes out, then b as normal
            if (esc_mode == MODE_HELD)
                beats.push_back({BACKSLASH, 1'b0, 1'b0});
            if (b == BACKSLASH)
                esc_mode = MODE_HELD;
            else
            begin
                esc_mode = MODE_NORMAL;
                beats.push_back({b, 1'b0, 1'b0});
            end
        end
        if (beats.size() != 0)
            beats[beats.size() - 1].last = 1'b1;
        foreach (beats[i])
            expected_utf8_q.push_back(beats[i]);
    endtask

    task automatic report_mismatch(input string what, input utf8_beat_t want);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s): expected data %02h bad %0d last %0d, ",
                      "got data %02h bad %0d last %0d"},
                     what, want.data, want.bad, want.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
    endtask

    always @(posedge clk)
    begin
        utf8_beat_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_utf8(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_utf8_q.size() == 0)
                    report_mismatch("unexpected beat", '0);
                else
                begin
                    want = expected_utf8_q.pop_front();
                    if (want.data !== m_axis_tdata || want.bad !== m_axis_tuser ||
                        want.last !== m_axis_tlast)
                        report_mismatch("field", want);
                end
            end
        end
    end

    initial
    begin : sink_ready
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_char(input logic [7:0] b, input logic fl);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= fl;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CH_0 + 8'(nib);
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_hex(b))
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // bad_pos < 0 gives a clean escape
    task automatic send_escape(input logic [15:0] cp, input int bad_pos);
        send_char(BACKSLASH, 1'b0);
        send_char(LETTER_U, 1'b0);
        for (int i = 0; i < 4; i++)
            send_char(i == bad_pos ? non_hex_char() : hex_char(cp[15 - 4 * i -: 4]), 1'b0);
    endtask

    task automatic send_random_unit();
        int          r;
        int          n;
        logic [15:0] cp;
        r = $urandom_range(99);
        if (r < 40)
            send_char(8'($urandom_range(255)), 1'b0);
        else if (r < 75)
        begin
            case ($urandom_range(2))
                0: cp = 16'($urandom_range(16'h007F));
                1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
                default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
            endcase
            send_escape(cp, $urandom_range(9) == 0 ? int'($urandom_range(3)) : -1);
        end
        else if (r < 85)
        begin
            send_char(BACKSLASH, 1'b0);
            send_char(8'($urandom_range(255)), 1'b0);
        end
        else if (r < 92)
        begin
            // escape cut short by a flush
            n = $urandom_range(3);
            send_char(BACKSLASH, 1'b0);
            if (n > 0 || $urandom_range(1))
                send_char(LETTER_U, 1'b0);
            for (int i = 0; i < n; i++)
                send_char(hex_char(4'($urandom_range(15))), 1'b0);
            send_char(8'($urandom_range(255)), 1'b1);
        end
        else
            send_char(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_utf8_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_text("\\uFFFF");
        send_text("\\uDbFf");
        send_text("\\u07fZ");
        send_text("\\\\x");
        send_text("\\");
        send_char(8'hFF, 1'b1);
        send_text("\\u1");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_random_stream(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            send_random_unit();
    endtask

    task automatic test_quiet_burst(input int count);
        quiet = 1'b1;
        test_random_stream(count);
        quiet = 1'b0;
    endtask

    task automatic test_output_hold(input int count);
        int target;
        target = items_sent + count;
        hold_requests++;
        // only escapes so the job queue fills while the output is held
        while (items_sent < target)
            send_escape(16'($urandom_range(16'hFFFF, 16'h0800)), -1);
    endtask

    initial
    begin
        mismatches    = 0;
        items_sent    = 0;
        hold_requests = 0;
        quiet         = 1'b0;
        esc_mode      = MODE_NORMAL;
        esc_digits    = '0;
        esc_code      = '0;
        esc_bad       = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random_stream(90);
        wait_drain();
        test_quiet_burst(60);
        test_output_hold(50);
        wait_drain();
        test_random_stream(30);

        wait_drain();
        repeat (10) @(posedge clk);
        mismatches += expected_utf8_q.size();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/uetu_pkg.sv
hdl/uetu_front.sv
hdl/uetu_queue.sv
hdl/uetu_back.sv
hdl/unicode_escape_to_utf8_unit.sv
tb/sv/unicode_escape_to_utf8_unit_tb.sv
